// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands on clk, disabled during rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge
`define TCCW_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define TCCW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define TCCW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/tccw_pkg.sv -----
// ----------------------------------------------------------------------------
// tccw_pkg
// codes, reset values and result word layout of the text console writer
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_FIRST = 8'h20;
  localparam logic [7:0] CHAR_LAST  = 8'h7F;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [15:0] CELL_RESET = 16'h0F20;

  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;
  localparam logic [3:0] FG_RESET = 4'hF;
  localparam logic [3:0] BG_RESET = 4'h0;

  // result word layout
  localparam int COL_LSB  = 0;
  localparam int ROW_LSB  = 7;
  localparam int LOC_LSB  = 12;
  localparam int SCR_BIT  = 23;
  localparam int CELL_LSB = 24;
  localparam int OUT_W    = 40;

endpackage

// ----- design/text_console_char_writer_top.sv -----
// ----------------------------------------------------------------------------
// text_console_char_writer_top
// text console engine with a cell memory of COLUMNS x ROWS words
// ----------------------------------------------------------------------------
// A put, read or unused-mode word passes from ST_IDLE to ST_DONE, where its
// result is registered on the output; a put that scrolls first copies each row
// up one row (ST_SCROLL) and blanks the last row (ST_BLANK), and a clear blanks
// every cell (ST_BLANK), all through the single write port of the cell
// memory, which moves one cell a cycle. One word is worked on at a time; the
// next is taken while a finished result waits on the output. After reset a
// clearing pass fills every cell of the memory before the first word
// is taken; register writes are taken at any time.
module text_console_char_writer_top #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // char_code[7:0], read_index[18:8], zero fill
  input  logic [1:0]  s_axis_tuser,  // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // cursor_column[6:0], cursor_row[11:7],
                                     // cursor_location[22:12], scrolled[23],
                                     // cell_data[39:24]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CELLS       = COLUMNS * ROWS;
  localparam int AW          = $clog2(CELLS);
  localparam int CW          = $clog2(COLUMNS);
  localparam int CTW         = $clog2(COLUMNS + TAB_STOP);
  localparam int RW          = $clog2(ROWS + 1);
  localparam int PW          = $clog2(TAB_STOP);
  localparam int XW          = (AW > 11) ? AW : 11;
  localparam int CXW         = (CW > 7) ? CW : 7;
  localparam int RXW         = (RW > 5) ? RW : 5;
  localparam int COPY_LAST   = (ROWS - 1) * COLUMNS - 1;
  localparam int BLANK_FIRST = (ROWS - 1) * COLUMNS;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_BLANK,
    ST_DONE
  } state_t;

  state_t          state;
  logic [AW-1:0]   ptr;
  logic [CW-1:0]   col;
  logic [RW-1:0]   row;
  logic [PW-1:0]   phase;
  logic [3:0]      fg;
  logic [3:0]      bg;
  logic            scroll_flag;
  logic            read_hit;
  logic            copy_pend;
  logic [AW-1:0]   copy_addr;
  logic [15:0]     rdata;
  logic [15:0]     mem [CELLS];

  logic            we;
  logic [AW-1:0]   wa;
  logic [15:0]     wd;
  logic            re;
  logic [AW-1:0]   ra;

  logic            s_fire;
  logic            apb_wr;
  logic [1:0]      mode;
  logic [7:0]      code;
  logic [XW-1:0]   rix_ext;
  logic            rix_ok;
  logic [15:0]     blank;
  logic [AW-1:0]   loc_cur;
  logic [CTW-1:0]  col_t;
  logic [PW-1:0]   ph_t;
  logic            inc_row;
  logic            wr_put;
  logic [RW-1:0]   row_t;
  logic            scroll_need;
  logic [XW-1:0]   loc_ext;
  logic [CXW-1:0]  col_ext;
  logic [RXW-1:0]  row_ext;

  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign apb_wr        = psel && penable && pwrite && pready;
  assign pready        = 1'b1;
  assign prdata        = (paddr[2] == tccw_pkg::REG_BG) ? {28'd0, bg} : {28'd0, fg};

  assign mode    = s_axis_tuser;
  assign code    = s_axis_tdata[7:0];
  assign rix_ext = XW'(s_axis_tdata[18:8]);
  assign rix_ok  = {1'b0, rix_ext} < (XW + 1)'(CELLS);
  assign blank   = {bg, fg, tccw_pkg::CHAR_SPACE};
  assign loc_cur = AW'(row) * AW'(COLUMNS) + AW'(col);

  assign loc_ext = XW'(loc_cur);
  assign col_ext = CXW'(col);
  assign row_ext = RXW'(row);

  // cursor update for one byte
  always_comb begin
    col_t   = CTW'(col);
    ph_t    = phase;
    inc_row = 1'b0;
    wr_put  = 1'b0;
    case (code)
      tccw_pkg::CHAR_BS: begin
        if (col != '0) begin
          col_t = CTW'(col) - CTW'(1);
          ph_t  = (phase == '0) ? PW'(TAB_STOP - 1) : phase - PW'(1);
        end
      end
      tccw_pkg::CHAR_TAB: begin
        col_t = CTW'(col) + CTW'(TAB_STOP) - CTW'(phase);
        ph_t  = '0;
      end
      tccw_pkg::CHAR_CR: begin
        col_t = '0;
        ph_t  = '0;
      end
      tccw_pkg::CHAR_LF: begin
        col_t   = '0;
        ph_t    = '0;
        inc_row = 1'b1;
      end
      default: begin
        if (code inside {[tccw_pkg::CHAR_FIRST:tccw_pkg::CHAR_LAST]}) begin
          wr_put = 1'b1;
          col_t  = CTW'(col) + CTW'(1);
          ph_t   = (phase == PW'(TAB_STOP - 1)) ? '0 : phase + PW'(1);
        end
      end
    endcase
    if (col_t >= CTW'(COLUMNS)) begin
      col_t   = '0;
      ph_t    = '0;
      inc_row = 1'b1;
    end
    row_t       = row + RW'(inc_row);
    scroll_need = (row_t == RW'(ROWS));
  end

  // memory port control
  always_comb begin
    we = 1'b0;
    wa = ptr;
    wd = blank;
    re = 1'b0;
    ra = ptr + AW'(COLUMNS);
    case (state)
      ST_INIT: begin
        we = 1'b1;
        wd = tccw_pkg::CELL_RESET;
      end
      ST_IDLE: begin
        if (s_fire && mode == tccw_pkg::MODE_PUT && wr_put) begin
          we = 1'b1;
          wa = loc_cur;
          wd = {bg, fg, code};
        end
        if (s_fire && mode == tccw_pkg::MODE_READ && rix_ok) begin
          re = 1'b1;
          ra = rix_ext[AW-1:0];
        end
      end
      ST_SCROLL: begin
        re = 1'b1;
      end
      ST_BLANK: begin
        we = !copy_pend;
      end
      default: begin
      end
    endcase
    if (copy_pend) begin
      we = 1'b1;
      wa = copy_addr;
      wd = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_INIT;
      ptr           <= '0;
      col           <= '0;
      row           <= '0;
      phase         <= '0;
      fg            <= tccw_pkg::FG_RESET;
      bg            <= tccw_pkg::BG_RESET;
      scroll_flag   <= 1'b0;
      read_hit      <= 1'b0;
      copy_pend     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (apb_wr) begin
        if (paddr[2] == tccw_pkg::REG_BG) begin
          bg <= pwdata[3:0];
        end else begin
          fg <= pwdata[3:0];
        end
      end
      copy_pend <= (state == ST_SCROLL);
      copy_addr <= ptr;
      if (m_axis_tvalid && m_axis_tready && state != ST_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          if (ptr == AW'(CELLS - 1)) begin
            ptr   <= '0;
            state <= ST_IDLE;
          end else begin
            ptr <= ptr + AW'(1);
          end
        end
        ST_IDLE: begin
          if (s_fire) begin
            scroll_flag <= 1'b0;
            read_hit    <= 1'b0;
            case (mode)
              tccw_pkg::MODE_PUT: begin
                col   <= col_t[CW-1:0];
                phase <= ph_t;
                if (scroll_need) begin
                  row         <= RW'(ROWS - 1);
                  scroll_flag <= 1'b1;
                  ptr         <= '0;
                  state       <= ST_SCROLL;
                end else begin
                  row   <= row_t;
                  state <= ST_DONE;
                end
              end
              tccw_pkg::MODE_CLEAR: begin
                col   <= '0;
                row   <= '0;
                phase <= '0;
                ptr   <= '0;
                state <= ST_BLANK;
              end
              tccw_pkg::MODE_READ: begin
                read_hit <= rix_ok;
                state    <= ST_DONE;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_SCROLL: begin
          if (ptr == AW'(COPY_LAST)) begin
            ptr   <= AW'(BLANK_FIRST);
            state <= ST_BLANK;
          end else begin
            ptr <= ptr + AW'(1);
          end
        end
        ST_BLANK: begin
          if (!copy_pend) begin
            if (ptr == AW'(CELLS - 1)) begin
              state <= ST_DONE;
            end else begin
              ptr <= ptr + AW'(1);
            end
          end
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {(read_hit ? rdata : 16'd0), scroll_flag, loc_ext[10:0],
                              row_ext[4:0], col_ext[6:0]};
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/tccw_checker.sv -----
// ----------------------------------------------------------------------------
// tccw_checker
// port-level checks of the text console writer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tccw_checker #(
  parameter int ROWS = 25
) (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  logic [1:0] pending;
  logic       in_acc;
  logic       out_acc;
  logic       scr;
  logic [6:0] col_f;
  logic [4:0] row_f;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign scr     = m_axis_tdata[tccw_pkg::SCR_BIT];
  assign col_f   = m_axis_tdata[tccw_pkg::COL_LSB +: 7];
  assign row_f   = m_axis_tdata[tccw_pkg::ROW_LSB +: 5];

  // words taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= pending + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  `TCCW_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

  `TCCW_ASSERT(a_pending_max, pending != 2'd3, "more than two words in flight")

  `TCCW_ASSERT_IMP(a_out_has_src, m_axis_tvalid, pending != 2'd0,
    "result word without a taken input word")

  `TCCW_ASSERT_IMP(a_scroll_pos, m_axis_tvalid && scr,
    col_f == 7'd0 && row_f == 5'(ROWS - 1), "scroll left cursor off the last row start")

  `TCCW_ASSERT_IMP(a_init_pass, $past(rst), !s_axis_tready && !m_axis_tvalid,
    "input taken or result shown right after reset")

endmodule

bind text_console_char_writer_top tccw_checker #(.ROWS(ROWS)) u_tccw_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
